/* hw/rtl/fifo_serial_transmitter_unit_assert.svh */
// Assertion macros shared by the transmitter RTL.
// Each module that uses them must have clk_i and rst_ni in scope.
`ifndef FIFO_SERIAL_TRANSMITTER_UNIT_ASSERT_SVH
`define FIFO_SERIAL_TRANSMITTER_UNIT_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define FST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define FST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* hw/rtl/fst_pkg.sv */
// Package for the serial transmitter: item types, FIFO sizing and frame slot codes.
// No dependencies.
`timescale 1ns / 1ps

package fst_pkg;

  localparam int unsigned FIFO_DEPTH = 16;
  localparam int unsigned FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned DIV_W      = 8;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned COUNT_OUT_W = 5;

  localparam logic [DIV_W-1:0]  TPB_RESET  = 8'd25;
  localparam logic [SLOT_W-1:0] SLOT_START = 4'd0;
  localparam logic [SLOT_W-1:0] SLOT_STOP1 = 4'd9;
  localparam logic [SLOT_W-1:0] SLOT_STOP2 = 4'd10;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_WRITE = 1'b1
  } fst_op_e;

  typedef struct packed {
    fst_op_e    op;
    logic [7:0] data;
  } fst_in_t;

  typedef struct packed {
    logic                   line;
    logic                   write_accepted;
    logic                   busy_res;
    logic [COUNT_OUT_W-1:0] fifo_count;
  } fst_out_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] data;
  } fst_fifo_ctl_t;

  typedef struct packed {
    logic       full;
    logic       empty;
    logic [7:0] head;
  } fst_fifo_stat_t;

endpackage

/* hw/rtl/fst_fifo.sv */
// Byte FIFO for the serial transmitter: register storage, pointers and fill count.
// Depends on fst_pkg.
`timescale 1ns / 1ps

module fst_fifo (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fst_pkg::fst_fifo_ctl_t              ctl_i,
  output fst_pkg::fst_fifo_stat_t             stat_o,
  output logic [fst_pkg::CNT_W-1:0]           count_next_o
);
  import fst_pkg::*;

  logic [7:0]         store_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;

  function automatic logic [FIFO_AW-1:0] ptr_inc(logic [FIFO_AW-1:0] p);
    return (p == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    rd_ptr_d = ctl_i.pop  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    wr_ptr_d = ctl_i.push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    count_d  = count_q;
    if (ctl_i.push && !ctl_i.pop) begin
      count_d = count_q + 1'b1;
    end else if (ctl_i.pop && !ctl_i.push) begin
      count_d = count_q - 1'b1;
    end
  end

  assign stat_o.full   = (count_q == CNT_W'(FIFO_DEPTH));
  assign stat_o.empty  = (count_q == '0);
  assign stat_o.head   = store_q[rd_ptr_q];
  assign count_next_o  = count_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      store_q[wr_ptr_q] <= ctl_i.data;
    end
  end

endmodule

/* hw/rtl/fst_framer.sv */
// Frame sequencer: bit-period divider, bit slot, shift byte and line level.
// Depends on fst_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "fifo_serial_transmitter_unit_assert.svh"

module fst_framer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  fst_pkg::fst_in_t              item_i,
  input  logic [fst_pkg::DIV_W-1:0]     tpb_i,
  input  fst_pkg::fst_fifo_stat_t       stat_i,
  output fst_pkg::fst_fifo_ctl_t        ctl_o,
  output logic                          line_o,
  output logic                          busy_o,
  output logic                          accepted_o
);
  import fst_pkg::*;

  logic              active_q, active_d;
  logic              line_q, line_d;
  logic [7:0]        shift_q, shift_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [DIV_W-1:0]  div_q, div_d;
  logic [DIV_W-1:0]  div_inc;
  logic              push, pop, accepted;

  assign div_inc = div_q + 1'b1;

  always_comb begin
    active_d = active_q;
    line_d   = line_q;
    shift_d  = shift_q;
    slot_d   = slot_q;
    div_d    = div_q;
    push     = 1'b0;
    pop      = 1'b0;
    accepted = 1'b0;
    if (item_i.op == OP_WRITE) begin
      if (active_q) begin
        // Busy: queue only, unless full.
        if (!stat_i.full) begin
          push     = 1'b1;
          accepted = 1'b1;
        end
      end else begin
        // Idle means the FIFO is empty: the byte goes straight to the shifter.
        accepted = 1'b1;
        active_d = 1'b1;
        shift_d  = item_i.data;
        slot_d   = SLOT_START;
        div_d    = '0;
      end
    end else if (active_q) begin
      div_d = (div_inc > tpb_i) ? '0 : div_inc;
      if (div_q == '0) begin
        case (slot_q)
          SLOT_START: begin
            line_d = 1'b0;
            slot_d = slot_q + 1'b1;
          end
          SLOT_STOP1: begin
            line_d = 1'b1;
            slot_d = slot_q + 1'b1;
          end
          SLOT_STOP2: begin
            if (stat_i.empty) begin
              // Drop to idle; the divider stays at zero.
              active_d = 1'b0;
              div_d    = div_q;
            end else begin
              pop     = 1'b1;
              shift_d = stat_i.head;
              slot_d  = SLOT_START;
            end
          end
          default: begin
            line_d  = shift_q[0];
            shift_d = {1'b0, shift_q[7:1]};
            slot_d  = slot_q + 1'b1;
          end
        endcase
      end
    end
  end

  assign ctl_o.push = fire_i & push;
  assign ctl_o.pop  = fire_i & pop;
  assign ctl_o.data = item_i.data;
  assign line_o     = line_d;
  assign busy_o     = active_d;
  assign accepted_o = accepted;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      line_q   <= 1'b1;
      shift_q  <= '0;
      slot_q   <= '0;
      div_q    <= '0;
    end else if (fire_i) begin
      active_q <= active_d;
      line_q   <= line_d;
      shift_q  <= shift_d;
      slot_q   <= slot_d;
      div_q    <= div_d;
    end
  end

  `FST_ASSERT(a_idle_div_zero, !active_q |-> (div_q == '0), "divider not zero while idle")
  `FST_ASSERT(a_slot_range, active_q |-> (slot_q <= SLOT_STOP2), "bit slot out of range")

endmodule

/* hw/rtl/fifo_serial_transmitter_unit.sv */
// Serial transmitter (8N2) with byte FIFO. Throughput: one item per cycle unless the
// output stalls; the state update runs in one pass from the input register to the result
// register. Reset: asynchronous active low; line high, idle, FIFO empty,
// ticks_per_bit_minus_one = 25. FIFO storage itself is not cleared.
// Depends on fst_pkg, fst_fifo, fst_framer and the assertion macro header.
`timescale 1ns / 1ps
`include "fifo_serial_transmitter_unit_assert.svh"

module fifo_serial_transmitter_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // item input channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  fst_pkg::fst_in_t           in_i,
  // result output channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output fst_pkg::fst_out_t          out_o,
  // configuration write: ticks_per_bit_minus_one
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [fst_pkg::DIV_W-1:0]  cfg_data_i
);
  import fst_pkg::*;

  logic             in_valid_q;
  fst_in_t          in_item_q;
  logic             out_valid_q;
  fst_out_t         out_item_q;
  fst_out_t         res;
  logic [DIV_W-1:0] tpb_q;
  logic             out_ready;
  logic             fire;
  logic             out_idle;

  fst_fifo_ctl_t    fifo_ctl;
  fst_fifo_stat_t   fifo_stat;
  logic [CNT_W-1:0] fifo_count_next;

  // Register always writable; user must make writes only while block is idle; unenforced.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpb_q <= TPB_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      tpb_q <= cfg_data_i;
    end
  end

  // Result register frees up when empty or when its item is taken this cycle.
  assign out_ready  = !out_valid_q || !out_stall_i;
  // Process the held item whenever the result register can take it.
  assign fire       = in_valid_q && out_ready;
  // Hold the input register only while its item is blocked downstream.
  assign in_stall_o = in_valid_q && !out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_item_q <= in_i;
    end
  end

  fst_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (fifo_ctl),
    .stat_o       (fifo_stat),
    .count_next_o (fifo_count_next)
  );

  fst_framer u_framer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .item_i     (in_item_q),
    .tpb_i      (tpb_q),
    .stat_i     (fifo_stat),
    .ctl_o      (fifo_ctl),
    .line_o     (res.line),
    .busy_o     (res.busy_res),
    .accepted_o (res.write_accepted)
  );

  // Report the count after this item, masked to the output field width.
  assign res.fifo_count = COUNT_OUT_W'(fifo_count_next);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_item_q;

  // A presented result that reports the transmitter idle.
  assign out_idle = out_valid_q && !out_item_q.busy_res;

  `FST_ASSERT(a_idle_fifo_empty, out_idle |-> out_item_q.fifo_count == '0, "queued while idle")
  `FST_ASSERT(a_idle_line_high, out_idle |-> out_item_q.line, "idle with line low")
  `FST_ASSERT(a_hold_blocked_item, in_stall_o |=> in_valid_q && $stable(in_item_q), "item lost")

endmodule
